>>> rtl/core/dq_pkg.sv
// Shared types and constants for the double-ended queue.
`timescale 1ns / 1ps
`default_nettype none
package dq_pkg;

  localparam int DQ_DEPTH    = 16;
  localparam int WORD_BITS   = 32;
  localparam int OP_BITS     = 3;
  localparam int ST_BITS     = 2;
  localparam int DQ_OCC_BITS = $clog2(DQ_DEPTH + 1);

  typedef enum logic [OP_BITS-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_BACK  = 3'd5
  } opcode_t;

  typedef enum logic [ST_BITS-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

endpackage
`default_nettype wire

>>> rtl/core/dq_in_if.sv
// Request channel: opcode and push word with valid/ready.
`timescale 1ns / 1ps
`default_nettype none
interface dq_in_if;
  import dq_pkg::*;

  logic                        valid;
  logic                        ready;
  logic [OP_BITS-1:0]          opcode;
  logic signed [WORD_BITS-1:0] push_value;

  modport source (output valid, output opcode, output push_value, input ready);
  modport sink   (input valid, input opcode, input push_value, output ready);
endinterface
`default_nettype wire

>>> rtl/core/dq_out_if.sv
// Result channel: read word, status, occupancy and empty flag with valid/ready.
`timescale 1ns / 1ps
`default_nettype none
interface dq_out_if #(
  parameter int OCC_BITS = dq_pkg::DQ_OCC_BITS
);
  import dq_pkg::*;

  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] read_value;
  logic [ST_BITS-1:0]          status;
  logic [OCC_BITS-1:0]         occupancy;
  logic                        is_empty;

  modport source (output valid, output read_value, output status, output occupancy,
                  output is_empty, input ready);
  modport sink   (input valid, input read_value, input status, input occupancy,
                  input is_empty, output ready);
endinterface
`default_nettype wire

>>> rtl/core/dq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [$clog2(DEPTH)-1:0]   waddr,
  input  wire logic [WIDTH-1:0]           wdata,
  input  wire logic                       re,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr,
  output logic      [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/double_ended_queue.sv
// Double-ended queue of signed words in a ring RAM, one result per request.
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+-------------------------------------------
//  in_chan  | in  | valid / ready | opcode, push_value
//  out_chan | out | valid / ready | read_value, status, occupancy, is_empty
//
// One request per cycle unless held; result is out the cycle after acceptance.
// Pointers update at the accepting edge; the RAM is written or read at that
// same edge, so a later request always sees earlier pushes.
// in_chan.ready drops only while a result is held and out_chan.ready is low.
// Synchronous reset empties the deque; RAM contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module double_ended_queue #(
  parameter int DEPTH = dq_pkg::DQ_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  dq_in_if.sink     in_chan,
  dq_out_if.source  out_chan
);
  import dq_pkg::*;

  localparam int IDX_BITS = $clog2(DEPTH);
  localparam int CNT_BITS = $clog2(DEPTH + 1);
  localparam int SUM_BITS = CNT_BITS + 1;
  localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(DEPTH - 1);
  localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);
  localparam logic [SUM_BITS-1:0] WRAP_SUM = SUM_BITS'(DEPTH);

  logic [IDX_BITS-1:0] head_r, head_nxt;
  logic [CNT_BITS-1:0] count_r, count_nxt;
  logic                out_valid_r;
  status_t             status_r, status_nxt;
  logic [CNT_BITS-1:0] occ_r;
  logic                empty_r;
  logic                from_ram_r, from_ram_nxt;
  logic                ones_r, ones_nxt;

  logic                accept;
  logic                we, re;
  logic [IDX_BITS-1:0] waddr, raddr;
  logic [WORD_BITS-1:0] ram_rdata;
  logic [SUM_BITS-1:0] back_sum, back_last;
  logic [IDX_BITS-1:0] back_wr, back_rd, front_prev, front_next;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;

  assign back_sum   = SUM_BITS'(head_r) + SUM_BITS'(count_r);
  assign back_last  = back_sum - SUM_BITS'(1);
  assign back_wr    = (back_sum >= WRAP_SUM) ? IDX_BITS'(back_sum - WRAP_SUM)
                                             : IDX_BITS'(back_sum);
  assign back_rd    = (back_last >= WRAP_SUM) ? IDX_BITS'(back_last - WRAP_SUM)
                                              : IDX_BITS'(back_last);
  assign front_prev = (head_r == '0) ? LAST_IDX : head_r - IDX_BITS'(1);
  assign front_next = (head_r == LAST_IDX) ? '0 : head_r + IDX_BITS'(1);

  always_comb begin
    head_nxt     = head_r;
    count_nxt    = count_r;
    we           = 1'b0;
    re           = 1'b0;
    waddr        = back_wr;
    raddr        = head_r;
    status_nxt   = ST_DONE;
    from_ram_nxt = 1'b0;
    ones_nxt     = 1'b0;
    case (opcode_t'(in_chan.opcode))
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (count_r == FULL_CNT) begin
          status_nxt = ST_FULL;
        end else begin
          we        = 1'b1;
          count_nxt = count_r + CNT_BITS'(1);
          if (opcode_t'(in_chan.opcode) == OP_PUSH_FRONT) begin
            head_nxt = front_prev;
            waddr    = front_prev;
          end
        end
      end
      OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK: begin
        if (count_r == '0) begin
          status_nxt = ST_EMPTY;
          ones_nxt   = 1'b1;
        end else begin
          re           = 1'b1;
          from_ram_nxt = 1'b1;
          if (opcode_t'(in_chan.opcode) == OP_POP_BACK ||
              opcode_t'(in_chan.opcode) == OP_PEEK_BACK) begin
            raddr = back_rd;
          end
          if (opcode_t'(in_chan.opcode) == OP_POP_FRONT) begin
            head_nxt  = front_next;
            count_nxt = count_r - CNT_BITS'(1);
          end else if (opcode_t'(in_chan.opcode) == OP_POP_BACK) begin
            count_nxt = count_r - CNT_BITS'(1);
          end
        end
      end
      default: ;
    endcase
  end

  dq_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we && accept),
    .waddr (waddr),
    .wdata (in_chan.push_value),
    .re    (re && accept),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (accept) begin
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result fields; RAM read data holds while no request is taken
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r   <= status_nxt;
      occ_r      <= count_nxt;
      empty_r    <= (count_nxt == '0);
      from_ram_r <= from_ram_nxt;
      ones_r     <= ones_nxt;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.read_value = from_ram_r ? ram_rdata : (ones_r ? '1 : '0);
  assign out_chan.status     = status_r;
  assign out_chan.occupancy  = occ_r;
  assign out_chan.is_empty   = empty_r;

endmodule
`default_nettype wire

>>> rtl/core/dq_checker.sv
// Port-level checks for the double-ended queue, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module dq_checker #(
  parameter int DEPTH    = dq_pkg::DQ_DEPTH,
  parameter int OCC_BITS = dq_pkg::DQ_OCC_BITS
) (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [dq_pkg::WORD_BITS-1:0]   out_read_value,
  input wire logic [dq_pkg::ST_BITS-1:0]     out_status,
  input wire logic [OCC_BITS-1:0]            out_occupancy,
  input wire logic                           out_is_empty
);
  import dq_pkg::*;

  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_item_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted item gave no result");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_empty == (out_occupancy == '0)))
    else $error("empty flag disagrees with occupancy");

  a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |->
      out_read_value == '0 && out_occupancy == OCC_BITS'(DEPTH))
    else $error("full status with wrong word or occupancy");

  a_empty_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |-> out_read_value == '1 && out_is_empty)
    else $error("empty status with wrong word or flag");

endmodule

bind double_ended_queue dq_checker #(
  .DEPTH    (DEPTH),
  .OCC_BITS ($clog2(DEPTH + 1))
) u_dq_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_read_value (out_chan.read_value),
  .out_status     (out_chan.status),
  .out_occupancy  (out_chan.occupancy),
  .out_is_empty   (out_chan.is_empty)
);
`default_nettype wire
